// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also runs through reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/cpe_pkg.sv -----
// Constants, widths and helper functions of the complementary pitch estimator
package cpe_pkg;

  // sample and result widths
  localparam int SAMPLE_W     = 16;
  localparam int OUT_W        = 25;
  localparam int CORDIC_STEPS = 16;

  // configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 21;
  localparam int CFG_WEIGHT_W = 16;
  localparam int CFG_PERIOD_W = 16;
  localparam int CFG_OFFSET_W = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_OFFSET  = CFG_IDX_W'(2);

  localparam logic [CFG_WEIGHT_W-1:0]        BLEND_RST  = CFG_WEIGHT_W'(64723);
  localparam logic [CFG_PERIOD_W-1:0]        PERIOD_RST = CFG_PERIOD_W'(131);
  localparam logic signed [CFG_OFFSET_W-1:0] OFFSET_RST = CFG_OFFSET_W'(211026);

  // square root datapath: (ay^2 + az^2) << 16
  localparam int SQ_W      = 2 * SAMPLE_W;
  localparam int DEN_SHIFT = 16;
  localparam int REM_W     = SQ_W + DEN_SHIFT;
  localparam int ROOT_W    = REM_W / 2;
  localparam logic [REM_W-1:0] BIT_INIT = REM_W'(1) << (REM_W - 2);

  // CORDIC datapath
  localparam int NUM_SHIFT = 8;
  localparam int CORD_W    = ROOT_W + 4;
  localparam int Z_W       = 25;
  localparam int ATAN_W    = 22;
  localparam int STEP_W    = $clog2(ROOT_W);

  // shared multiplier
  localparam int MUL_A_W = (SAMPLE_W + 2 > 18) ? SAMPLE_W + 2 : 18;
  localparam int MUL_B_W = 28;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int PRED_W  = MUL_B_W;
  localparam int ONE_Q16 = 65536;

  localparam int RATE_SHIFT = 6;
  localparam int MIX_SHIFT  = 16;
  localparam logic signed [PROD_W-1:0] RATE_RND = PROD_W'(32);
  localparam logic signed [PROD_W-1:0] MIX_RND  = PROD_W'(32768);

  // saturation
  localparam int SAT_IN_W = PROD_W - MIX_SHIFT;
  localparam logic signed [OUT_W-1:0]    OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0]    OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic signed [SAT_IN_W-1:0] SAT_HI  = SAT_IN_W'(OUT_MAX);
  localparam logic signed [SAT_IN_W-1:0] SAT_LO  = SAT_IN_W'(OUT_MIN);

  // atan(2^-i) in degrees, Q8.16, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      STEP_W'(0):  v = ATAN_W'(2949120);
      STEP_W'(1):  v = ATAN_W'(1740967);
      STEP_W'(2):  v = ATAN_W'(919879);
      STEP_W'(3):  v = ATAN_W'(466945);
      STEP_W'(4):  v = ATAN_W'(234379);
      STEP_W'(5):  v = ATAN_W'(117304);
      STEP_W'(6):  v = ATAN_W'(58666);
      STEP_W'(7):  v = ATAN_W'(29335);
      STEP_W'(8):  v = ATAN_W'(14668);
      STEP_W'(9):  v = ATAN_W'(7334);
      STEP_W'(10): v = ATAN_W'(3667);
      STEP_W'(11): v = ATAN_W'(1833);
      STEP_W'(12): v = ATAN_W'(917);
      STEP_W'(13): v = ATAN_W'(458);
      STEP_W'(14): v = ATAN_W'(229);
      STEP_W'(15): v = ATAN_W'(115);
      STEP_W'(16): v = ATAN_W'(57);
      STEP_W'(17): v = ATAN_W'(29);
      STEP_W'(18): v = ATAN_W'(14);
      STEP_W'(19): v = ATAN_W'(7);
      STEP_W'(20): v = ATAN_W'(4);
      STEP_W'(21): v = ATAN_W'(2);
      STEP_W'(22): v = ATAN_W'(1);
      default:     v = '0;
    endcase
    return v;
  endfunction

  // clamp a wide angle to the output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_IN_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_HI) begin
      r = OUT_MAX;
    end else if (v < SAT_LO) begin
      r = OUT_MIN;
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

endpackage

// ----- rtl/complementary_pitch_estimator_top.sv -----
// Complementary pitch estimator: sequencer, square root, CORDIC and shared multiplier
//
// Usage:
//   Input channel (in_valid/in_ready): one IMU sample per beat, accelerometer
//   x/y/z in 1/16384 g and pitch rate in 1/64 deg/s, all two's complement.
//   Result channel (out_valid/out_ready): one beat per sample carrying the
//   blended pitch estimate and the accelerometer pitch, Q8.16 degrees.
//   Configuration port (cfg_we/cfg_index/cfg_wdata): blend weight, sample
//   period and pitch offset; write it only while the block is idle.
//   Sequence: the result beat is offered from the final state once the output
//   register is free. The 24-step square root and the CORDIC_STEPS
//   vectoring loop dominate; the shared multiplier makes five passes.
//   Flow: one sample in flight at a time; in_ready is high only while the
//   sequencer is idle.
//   Stall: a finished result sits in the output register; the next sample is
//   taken and worked on meanwhile, and its result waits in the final state
//   until the output register frees up.
//   Reset: clears the sequencer, the output valid, the pitch estimate (to
//   zero) and restores the configuration defaults.
`include "assert_macros.svh"

module complementary_pitch_estimator_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [cpe_pkg::SAMPLE_W-1:0]   in_accel_x,
  input  logic signed [cpe_pkg::SAMPLE_W-1:0]   in_accel_y,
  input  logic signed [cpe_pkg::SAMPLE_W-1:0]   in_accel_z,
  input  logic signed [cpe_pkg::SAMPLE_W-1:0]   in_pitch_rate,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cpe_pkg::OUT_W-1:0]      out_pitch_estimate,
  output logic signed [cpe_pkg::OUT_W-1:0]      out_accel_pitch,
  input  logic                                  cfg_we,
  input  logic [cpe_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cpe_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  // one-hot sequencer states
  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_MUL_Y    = 14'b00000000000010,
    ST_MUL_Z    = 14'b00000000000100,
    ST_SQ_INIT  = 14'b00000000001000,
    ST_SQRT     = 14'b00000000010000,
    ST_CORD_LD  = 14'b00000000100000,
    ST_CORDIC   = 14'b00000001000000,
    ST_OFFSET   = 14'b00000010000000,
    ST_MUL_RATE = 14'b00000100000000,
    ST_PRED     = 14'b00001000000000,
    ST_MUL_A    = 14'b00010000000000,
    ST_MUL_B    = 14'b00100000000000,
    ST_FIN      = 14'b01000000000000,
    ST_DONE     = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [cpe_pkg::CFG_WEIGHT_W-1:0]        blend_weight_r;
  logic [cpe_pkg::CFG_PERIOD_W-1:0]        sample_period_r;
  logic signed [cpe_pkg::CFG_OFFSET_W-1:0] pitch_offset_r;

  // captured sample
  logic signed [cpe_pkg::SAMPLE_W-1:0] ax_r, ay_r, az_r, rate_r;

  // square root
  logic [cpe_pkg::SQ_W-2:0]    sq_r;
  logic [cpe_pkg::REM_W-1:0]   rem_r, root_r, bit_r, trial;
  logic                        take_bit;
  logic [cpe_pkg::ROOT_W-1:0]  denom;

  // CORDIC
  logic [cpe_pkg::STEP_W-1:0]        step_r;
  logic signed [cpe_pkg::CORD_W-1:0] x_r, y_r, x_sh, y_sh;
  logic signed [cpe_pkg::Z_W-1:0]    z_r, atan_step;

  // shared multiplier and blend
  logic signed [cpe_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [cpe_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [cpe_pkg::PROD_W-1:0]   mul_p, prod_r, mix_r, rate_sum, fin_sum;
  logic                                mul_en;
  logic signed [cpe_pkg::SAT_IN_W-1:0] acc_sum;
  logic signed [cpe_pkg::PRED_W-1:0]   pred_r;
  logic signed [cpe_pkg::OUT_W-1:0]    acc_r, pitch_state_r;

  // output register
  logic                             out_valid_r;
  logic signed [cpe_pkg::OUT_W-1:0] out_est_r, out_acc_r;
  logic                             out_load;

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_pitch_estimate = out_est_r;
  assign out_accel_pitch    = out_acc_r;

  // the result may leave the final state once the output register is free
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_MUL_Y;
      ST_MUL_Y:    state_nxt = ST_MUL_Z;
      ST_MUL_Z:    state_nxt = ST_SQ_INIT;
      ST_SQ_INIT:  state_nxt = ST_SQRT;
      ST_SQRT:     if (step_r == cpe_pkg::STEP_W'(cpe_pkg::ROOT_W - 1)) state_nxt = ST_CORD_LD;
      ST_CORD_LD:  state_nxt = ST_CORDIC;
      ST_CORDIC: begin
        if (step_r == cpe_pkg::STEP_W'(cpe_pkg::CORDIC_STEPS - 1)) state_nxt = ST_OFFSET;
      end
      ST_OFFSET:   state_nxt = ST_MUL_RATE;
      ST_MUL_RATE: state_nxt = ST_PRED;
      ST_PRED:     state_nxt = ST_MUL_A;
      ST_MUL_A:    state_nxt = ST_MUL_B;
      ST_MUL_B:    state_nxt = ST_FIN;
      ST_FIN:      state_nxt = ST_DONE;
      ST_DONE:     if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state_r)
      ST_MUL_Y: begin
        mul_a = cpe_pkg::MUL_A_W'(ay_r);
        mul_b = cpe_pkg::MUL_B_W'(ay_r);
      end
      ST_MUL_Z: begin
        mul_a = cpe_pkg::MUL_A_W'(az_r);
        mul_b = cpe_pkg::MUL_B_W'(az_r);
      end
      ST_MUL_RATE: begin
        mul_a = cpe_pkg::MUL_A_W'(sample_period_r);
        mul_b = cpe_pkg::MUL_B_W'(rate_r);
      end
      ST_MUL_A: begin
        mul_a = cpe_pkg::MUL_A_W'(blend_weight_r);
        mul_b = pred_r;
      end
      ST_MUL_B: begin
        mul_a = cpe_pkg::MUL_A_W'(cpe_pkg::ONE_Q16) - cpe_pkg::MUL_A_W'(blend_weight_r);
        mul_b = cpe_pkg::MUL_B_W'(acc_r);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // square-root step: one result bit per cycle
  assign trial    = root_r + bit_r;
  assign take_bit = (rem_r >= trial);
  // a zero denominator becomes one LSB
  assign denom    = (root_r[cpe_pkg::ROOT_W-1:0] == '0) ? cpe_pkg::ROOT_W'(1)
                                                          : root_r[cpe_pkg::ROOT_W-1:0];

  // CORDIC vectoring step: x and y each shifted right by the step index
  assign x_sh      = x_r >>> step_r;
  assign y_sh      = y_r >>> step_r;
  assign atan_step = cpe_pkg::Z_W'(cpe_pkg::atan_lut(step_r));

  // offset, rate rounding and blend rounding
  assign acc_sum  = cpe_pkg::SAT_IN_W'(z_r) + cpe_pkg::SAT_IN_W'(pitch_offset_r);
  assign rate_sum = prod_r + cpe_pkg::RATE_RND;
  assign fin_sum  = mix_r + prod_r;

  // control state, configuration and estimate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      pitch_state_r   <= '0;
      blend_weight_r  <= cpe_pkg::BLEND_RST;
      sample_period_r <= cpe_pkg::PERIOD_RST;
      pitch_offset_r  <= cpe_pkg::OFFSET_RST;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_FIN) begin
        pitch_state_r <= cpe_pkg::sat_out(
          signed'(fin_sum[cpe_pkg::PROD_W-1:cpe_pkg::MIX_SHIFT]));
      end
      if (cfg_we) begin
        unique case (cfg_index)
          cpe_pkg::CFG_BLEND_WEIGHT:  blend_weight_r  <= cfg_wdata[cpe_pkg::CFG_WEIGHT_W-1:0];
          cpe_pkg::CFG_SAMPLE_PERIOD: sample_period_r <= cfg_wdata[cpe_pkg::CFG_PERIOD_W-1:0];
          cpe_pkg::CFG_PITCH_OFFSET:  pitch_offset_r  <= signed'(cfg_wdata[cpe_pkg::CFG_OFFSET_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ax_r   <= in_accel_x;
      ay_r   <= in_accel_y;
      az_r   <= in_accel_z;
      rate_r <= in_pitch_rate;
    end

    if (mul_en) begin
      prod_r <= mul_p;
    end

    unique case (state_r)
      ST_MUL_Z: sq_r <= prod_r[cpe_pkg::SQ_W-2:0];
      ST_SQ_INIT: begin
        rem_r  <= {cpe_pkg::SQ_W'(sq_r) + prod_r[cpe_pkg::SQ_W-1:0],
                   cpe_pkg::DEN_SHIFT'(0)};
        root_r <= '0;
        bit_r  <= cpe_pkg::BIT_INIT;
        step_r <= '0;
      end
      ST_SQRT: begin
        if (take_bit) begin
          rem_r  <= rem_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        step_r <= step_r + cpe_pkg::STEP_W'(1);
      end
      ST_CORD_LD: begin
        x_r    <= cpe_pkg::CORD_W'(denom);
        y_r    <= -(cpe_pkg::CORD_W'(ax_r) <<< cpe_pkg::NUM_SHIFT);
        z_r    <= '0;
        step_r <= '0;
      end
      ST_CORDIC: begin
        if (!y_r[cpe_pkg::CORD_W-1]) begin
          x_r <= x_r + y_sh;
          y_r <= y_r - x_sh;
          z_r <= z_r + atan_step;
        end else begin
          x_r <= x_r - y_sh;
          y_r <= y_r + x_sh;
          z_r <= z_r - atan_step;
        end
        step_r <= step_r + cpe_pkg::STEP_W'(1);
      end
      ST_OFFSET: acc_r <= cpe_pkg::sat_out(acc_sum);
      ST_PRED: begin
        pred_r <= cpe_pkg::PRED_W'(pitch_state_r)
                + cpe_pkg::PRED_W'(signed'(rate_sum[cpe_pkg::PROD_W-1:cpe_pkg::RATE_SHIFT]));
      end
      ST_MUL_B: mix_r <= prod_r + cpe_pkg::MIX_RND;
      default: ;
    endcase

    if (out_load) begin
      out_est_r <= pitch_state_r;
      out_acc_r <= acc_r;
    end
  end

  // checks
  `ASSERT_CLK_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ST_IDLE) && !out_valid_r, "reset did not clear sequencer or output valid")
  `ASSERT_CLK(a_accept_starts, in_valid && in_ready |=> state_r == ST_MUL_Y, "accepted beat did not start the sequence")
  `ASSERT_CLK(a_denom_nonzero, state_r == ST_CORD_LD |=> x_r != '0, "CORDIC loaded with zero denominator")
  `ASSERT_CLK(a_cordic_x_pos, state_r == ST_CORDIC |-> !x_r[cpe_pkg::CORD_W-1], "CORDIC x went negative")
  `ASSERT_CLK(a_hold_result, state_r == ST_DONE && out_valid_r && !out_ready |=> state_r == ST_DONE, "result left while output register was full")

endmodule
